/* rtl/rhcc_pkg.sv */
// Shared types, constants and trig tables of the RGB hue color classifier.
package rhcc_pkg;

   localparam int TRIG_W = 53;
   localparam int TRIG_N = 64;
   localparam int DEG_LAST = 44;

   typedef logic [TRIG_W-1:0] trig_tab_type [0:TRIG_N-1];

   typedef enum logic [1:0] {
      MODE_GREY,
      MODE_NORMAL,
      MODE_DIAG,
      MODE_SWAP
   } hue_mode_type;

   localparam logic [3:0] CLS_YELLOW  = 4'd0;
   localparam logic [3:0] CLS_RED     = 4'd1;
   localparam logic [3:0] CLS_GREEN   = 4'd2;
   localparam logic [3:0] CLS_BLUE    = 4'd3;
   localparam logic [3:0] CLS_BROWN   = 4'd4;
   localparam logic [3:0] CLS_ORANGE  = 4'd5;
   localparam logic [3:0] CLS_CYAN    = 4'd6;
   localparam logic [3:0] CLS_SKY     = 4'd7;
   localparam logic [3:0] CLS_MAGENTA = 4'd8;
   localparam logic [3:0] CLS_PINK    = 4'd9;
   localparam logic [3:0] CLS_WHITE   = 4'd10;
   localparam logic [3:0] CLS_BLACK   = 4'd11;
   localparam logic [3:0] CLS_UNKNOWN = 4'd12;

   localparam logic [63:0] ONE60 = 64'd1 << 60;
   localparam logic [63:0] PI60  = 64'h3243F6A8885A308D;

   // (a * b) >> 60 on the full product
   function automatic logic [63:0] mulfx(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[123:60];
   endfunction

   // Taylor series of sin or cos of whole degrees, 60 fraction bits, kept at 52
   function automatic trig_tab_type trig_table(input logic want_cos);
      trig_tab_type tab;
      logic [63:0] rad1;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] s_r;
      logic [63:0] c_r;
      rad1 = PI60 / 64'd180;
      for (int d = 0; d < TRIG_N; d++) begin
         if (d <= DEG_LAST) begin
            x  = rad1 * 64'(d);
            x2 = mulfx(x, x);
            t  = x;
            s  = x;
            for (int k = 1; k <= 12; k++) begin
               t = mulfx(t, x2) / 64'((2 * k) * (2 * k + 1));
               if ((k % 2) == 1) s = s - t;
               else s = s + t;
            end
            t = ONE60;
            c = ONE60;
            for (int k = 1; k <= 12; k++) begin
               t = mulfx(t, x2) / 64'((2 * k - 1) * (2 * k));
               if ((k % 2) == 1) c = c - t;
               else c = c + t;
            end
            s_r = (s + 64'd128) >> 8;
            c_r = (c + 64'd128) >> 8;
            tab[d] = want_cos ? c_r[TRIG_W-1:0] : s_r[TRIG_W-1:0];
         end else begin
            tab[d] = '0;
         end
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN52 = trig_table(1'b0);
   localparam trig_tab_type COS52 = trig_table(1'b1);

endpackage

/* rtl/rhcc_prep.sv */
// Front stages: chroma vector, luminosity, square sums and octant folding.
module rhcc_prep import rhcc_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [7:0]         red_level,
   input  logic [7:0]         green_level,
   input  logic [7:0]         blue_level,
   output logic [7:0]         big_ff,
   output logic [7:0]         small_ff,
   output hue_mode_type       mode_ff,
   output logic [1:0]         quad_ff,
   output logic [9:0]         lum2_ff,
   output logic [17:0]        sumsq2_ff,
   output logic [19:0]        lsq_ff
);

   localparam logic signed [33:0] IM_MUL = 34'sd14529495;

   logic signed [9:0]  re_ff, re_in;
   logic signed [33:0] v_ff, v_in;
   logic [9:0]         lum_ff, lum_in;
   logic [17:0]        sumsq_ff, sumsq_in;
   logic signed [9:0]  diff;
   logic signed [9:0]  im;
   logic signed [9:0]  x, y;
   logic [7:0]         big_in, small_in;
   hue_mode_type       mode_in;
   logic [1:0]         quad_in;

   always_comb begin
      diff     = signed'(10'(green_level) - 10'(blue_level));
      re_in    = signed'(10'(red_level) - 10'((9'(green_level) + 9'(blue_level)) >> 1));
      v_in     = 34'(diff) * IM_MUL;
      lum_in   = 10'(red_level) + 10'(green_level) + 10'(blue_level);
      sumsq_in = 18'(16'(red_level) * 16'(red_level))
               + 18'(16'(green_level) * 16'(green_level))
               + 18'(16'(blue_level) * 16'(blue_level));
   end

   // floor shift of the product gives im rounded toward minus infinity
   always_comb begin
      im = 10'(v_ff >>> 24);
      if (re_ff > 0 && im >= 0) begin
         quad_in = 2'd0; x = re_ff; y = im;
      end else if (re_ff <= 0 && im > 0) begin
         quad_in = 2'd1; x = im; y = -re_ff;
      end else if (re_ff < 0 && im <= 0) begin
         quad_in = 2'd2; x = -re_ff; y = -im;
      end else begin
         quad_in = 2'd3; x = -im; y = re_ff;
      end
      if (re_ff == 0 && im == 0) begin
         mode_in  = MODE_GREY;
         big_in   = x[7:0];
         small_in = y[7:0];
      end else if (y < x) begin
         mode_in  = MODE_NORMAL;
         big_in   = x[7:0];
         small_in = y[7:0];
      end else if (y == x) begin
         mode_in  = MODE_DIAG;
         big_in   = x[7:0];
         small_in = y[7:0];
      end else begin
         mode_in  = MODE_SWAP;
         big_in   = y[7:0];
         small_in = x[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         re_ff     <= re_in;
         v_ff      <= v_in;
         lum_ff    <= lum_in;
         sumsq_ff  <= sumsq_in;
         big_ff    <= big_in;
         small_ff  <= small_in;
         mode_ff   <= mode_in;
         quad_ff   <= quad_in;
         lum2_ff   <= lum_ff;
         sumsq2_ff <= sumsq_ff;
         lsq_ff    <= 20'(lum_ff) * 20'(lum_ff);
      end
   end

endmodule

/* rtl/rhcc_atan.sv */
// Hue pipeline: binary search of the octant angle, one degree test per stage.
module rhcc_atan import rhcc_pkg::*; (
   input  logic         clock,
   input  logic         enable,
   input  logic [7:0]   big,
   input  logic [7:0]   minor,
   input  hue_mode_type mode,
   input  logic [1:0]   quad,
   output logic [8:0]   hue_ff
);

   localparam int STEPS = 6;

   logic [7:0]   big_ff   [0:STEPS-1];
   logic [7:0]   small_ff [0:STEPS-1];
   hue_mode_type mode_ff  [0:STEPS-1];
   logic [1:0]   quad_ff  [0:STEPS-1];
   logic [5:0]   lo_ff    [0:STEPS-1];
   logic [8:0]   hue_in;
   logic [8:0]   phi;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [7:0]   big_s, small_s;
      hue_mode_type mode_s;
      logic [1:0]   quad_s;
      logic [5:0]   lo_s, cand, lo_in;
      logic [60:0]  lhs, rhs;

      if (k == 0) begin : g_first
         assign big_s   = big;
         assign small_s = minor;
         assign mode_s  = mode;
         assign quad_s  = quad;
         assign lo_s    = '0;
      end else begin : g_next
         assign big_s   = big_ff[k-1];
         assign small_s = small_ff[k-1];
         assign mode_s  = mode_ff[k-1];
         assign quad_s  = quad_ff[k-1];
         assign lo_s    = lo_ff[k-1];
      end

      // advance lo when the point lies above the candidate degree line
      always_comb begin
         cand  = lo_s + 6'(32 >> k);
         lhs   = 61'(small_s) * 61'(COS52[cand]);
         rhs   = 61'(big_s) * 61'(SIN52[cand]);
         lo_in = (cand <= 6'(DEG_LAST) && lhs > rhs) ? cand : lo_s;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            big_ff[k]   <= big_s;
            small_ff[k] <= small_s;
            mode_ff[k]  <= mode_s;
            quad_ff[k]  <= quad_s;
            lo_ff[k]    <= lo_in;
         end
      end
   end

   always_comb begin
      unique case (mode_ff[STEPS-1])
         MODE_NORMAL: phi = 9'(lo_ff[STEPS-1]);
         MODE_DIAG:   phi = 9'd45;
         MODE_SWAP:   phi = 9'd89 - 9'(lo_ff[STEPS-1]);
         default:     phi = '0;
      endcase
      if (mode_ff[STEPS-1] == MODE_GREY) hue_in = '0;
      else hue_in = 9'(quad_ff[STEPS-1]) * 9'd90 + phi;
   end

   always_ff @(posedge clock) begin
      if (enable) hue_ff <= hue_in;
   end

endmodule

/* rtl/rhcc_isqrt.sv */
// Saturation pipeline: spread measure, then digit-by-digit square root.
module rhcc_isqrt import rhcc_pkg::*; (
   input  logic        clock,
   input  logic        enable,
   input  logic [17:0] sumsq,
   input  logic [19:0] lsq,
   output logic [7:0]  sat
);

   localparam int ROOT_STAGES = 4;
   // floor(n / 3) as (n * ceil(2^21 / 3)) >> 21, exact below 2^20
   localparam logic [20:0] THIRD_MUL = 21'd699051;

   logic [15:0] rem_ff [0:ROOT_STAGES];
   logic [15:0] res_ff [0:ROOT_STAGES];
   logic [40:0] third_prod;
   logic [17:0] spread;

   function automatic logic [31:0] root_step(input logic [15:0] rem, input logic [15:0] res,
                                             input int k);
      logic [16:0] bit_v;
      logic [16:0] trial;
      logic [15:0] rem_o;
      logic [15:0] res_o;
      bit_v = 17'd1 << (14 - 2 * k);
      trial = 17'(res) + bit_v;
      if (17'(rem) >= trial) begin
         rem_o = rem - trial[15:0];
         res_o = (res >> 1) + bit_v[15:0];
      end else begin
         rem_o = rem;
         res_o = res >> 1;
      end
      return {rem_o, res_o};
   endfunction

   always_comb begin
      third_prod = 41'(lsq) * 41'(THIRD_MUL);
      spread     = sumsq - 18'(third_prod >> 21);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= spread[15:0];
         res_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_root
      logic [31:0] s0, s1;
      always_comb begin
         s0 = root_step(rem_ff[j], res_ff[j], 2 * j);
         s1 = root_step(s0[31:16], s0[15:0], 2 * j + 1);
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j+1] <= s1[31:16];
            res_ff[j+1] <= s1[15:0];
         end
      end
   end

   assign sat = res_ff[ROOT_STAGES][7:0];

endmodule

/* rtl/rgb_hue_color_classifier.sv */
// Top level of the RGB hue color classifier: pipeline control and color windows.
//
// Usage: one RGB pixel enters on the req_ channel (req_valid, req_stall) and one
// result leaves on the rsp_ channel (rsp_valid, rsp_stall) with the color class,
// hue in whole degrees, luminosity and saturation of that pixel.
// Throughput: one pixel per cycle when the receiver does not stall; the depth
// is set by the six-step hue search and the square root, each spread over
// register stages.
// All stages move together: when a result waits at the output and rsp_stall is
// high, the whole pipeline holds and req_stall goes high in the same cycle, so
// nothing is dropped or repeated. A result already at the output can be taken
// while the next request is accepted.
// Reset (synchronous, active high) clears all stage valid bits and the output
// valid; payload registers keep whatever they hold. No tables need loading after
// reset: the trig constants are fixed.
module rgb_hue_color_classifier import rhcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red_level,
   input  logic [7:0] req_green_level,
   input  logic [7:0] req_blue_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_color_class,
   output logic [8:0] rsp_hue_degrees,
   output logic [9:0] rsp_luminosity,
   output logic [7:0] rsp_saturation
);

   localparam int DEPTH = 9;
   localparam int LUM_DLY = 7;
   localparam int SAT_DLY = 2;

   logic         enable;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   rsp_class_ff;
   logic [8:0]   rsp_hue_ff;
   logic [9:0]   rsp_lum_ff;
   logic [7:0]   rsp_sat_ff;
   logic [7:0]   big, minor;
   hue_mode_type mode;
   logic [1:0]   quad;
   logic [9:0]   lum2;
   logic [17:0]  sumsq2;
   logic [19:0]  lsq;
   logic [8:0]   hue;
   logic [7:0]   sat;
   logic [9:0]   lum_dly_ff [0:LUM_DLY-1];
   logic [7:0]   sat_dly_ff [0:SAT_DLY-1];
   logic [3:0]   class_in;
   logic [9:0]   l;
   logic [7:0]   s;

   // hold everything while a result waits on a stalled receiver
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   rhcc_prep u_prep (
      .clock       (clock),
      .enable      (enable),
      .red_level   (req_red_level),
      .green_level (req_green_level),
      .blue_level  (req_blue_level),
      .big_ff      (big),
      .small_ff    (minor),
      .mode_ff     (mode),
      .quad_ff     (quad),
      .lum2_ff     (lum2),
      .sumsq2_ff   (sumsq2),
      .lsq_ff      (lsq)
   );

   rhcc_atan u_atan (
      .clock  (clock),
      .enable (enable),
      .big    (big),
      .minor  (minor),
      .mode   (mode),
      .quad   (quad),
      .hue_ff (hue)
   );

   rhcc_isqrt u_isqrt (
      .clock  (clock),
      .enable (enable),
      .sumsq  (sumsq2),
      .lsq    (lsq),
      .sat    (sat)
   );

   always_comb begin
      vld_in       = {vld_ff[DEPTH-2:0], req_valid};
      rsp_valid_in = vld_ff[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lum_dly_ff[0] <= lum2;
         for (int i = 1; i < LUM_DLY; i++) lum_dly_ff[i] <= lum_dly_ff[i-1];
         sat_dly_ff[0] <= sat;
         for (int i = 1; i < SAT_DLY; i++) sat_dly_ff[i] <= sat_dly_ff[i-1];
      end
   end

   // first matching window wins
   always_comb begin
      l = lum_dly_ff[LUM_DLY-1];
      s = sat_dly_ff[SAT_DLY-1];
      priority if (hue >= 9'd30 && hue < 9'd90 && l >= 10'd200)
         class_in = CLS_YELLOW;
      else if ((hue < 9'd30 || hue >= 9'd270) && s >= 8'd15)
         class_in = CLS_RED;
      else if (hue >= 9'd90 && hue < 9'd200 && s >= 8'd10)
         class_in = CLS_GREEN;
      else if (hue >= 9'd200 && hue <= 9'd270 && s >= 8'd15)
         class_in = CLS_BLUE;
      else if (hue >= 9'd20 && hue < 9'd40 && l < 10'd383 && s >= 8'd30)
         class_in = CLS_BROWN;
      else if (hue >= 9'd20 && hue < 9'd45 && l >= 10'd383 && s >= 8'd30)
         class_in = CLS_ORANGE;
      else if (hue >= 9'd150 && hue < 9'd210 && s >= 8'd45)
         class_in = CLS_CYAN;
      else if (hue >= 9'd210 && hue <= 9'd270 && l >= 10'd383 && s >= 8'd60)
         class_in = CLS_SKY;
      else if (hue >= 9'd270 && hue < 9'd330 && l < 10'd574 && s >= 8'd42)
         class_in = CLS_MAGENTA;
      else if (hue >= 9'd270 && hue < 9'd330 && l >= 10'd574 && s >= 8'd42)
         class_in = CLS_PINK;
      else if (s < 8'd30 && l >= 10'd665)
         class_in = CLS_WHITE;
      else if (s < 8'd30 && l <= 10'd100)
         class_in = CLS_BLACK;
      else
         class_in = CLS_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_class_ff <= class_in;
         rsp_hue_ff   <= hue;
         rsp_lum_ff   <= l;
         rsp_sat_ff   <= s;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_class = rsp_class_ff;
   assign rsp_hue_degrees = rsp_hue_ff;
   assign rsp_luminosity  = rsp_lum_ff;
   assign rsp_saturation  = rsp_sat_ff;

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue_degrees < 9'd360)
      else $error("hue out of range");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color_class <= CLS_UNKNOWN)
      else $error("color class out of range");

   a_white_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_class == CLS_WHITE |->
         rsp_saturation < 8'd30 && rsp_luminosity >= 10'd665)
      else $error("white outside its window");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue_degrees)
         && $stable(rsp_saturation))
      else $error("stalled result changed");

endmodule
